FILE: sv/transposed_form_iir_fir_filter_defines.svh
// Assertion macros for the transposed form filter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef TRANSPOSED_FORM_IIR_FIR_FILTER_DEFINES_SVH
`define TRANSPOSED_FORM_IIR_FIR_FILTER_DEFINES_SVH

// ante holds in the same cycle as cons
`define TFF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante in one cycle, cons in the next
`define TFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tff_pkg.sv
// Shared types and constants of the transposed form filter.
// No dependencies; imported by the controller, datapath and top level.
package tff_pkg;

    localparam int SMP_W   = 16;  // Q1.15 sample
    localparam int COEF_W  = 16;  // Q2.14 coefficient
    localparam int DLY_W   = 40;  // delay entry, scale 2^-29
    localparam int ACC_W   = 41;  // x*b0 + z0
    localparam int OP_W    = 25;  // wide operand of the shared multipliers
    localparam int PRD_W   = OP_W + COEF_W;
    localparam int SCL_W   = 57;  // acc * lead_recip, scale 2^-43
    localparam int SUM_W   = 42;  // z + x*b - y*a before saturation
    localparam int RND_W   = 29;  // rounded result before saturation
    localparam int ACC_SPLIT = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TAPS_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 2'd2;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FWD    = 2'd1;
    localparam logic [1:0] KIND_FBK    = 2'd2;

    localparam logic [1:0] MODE_PZ  = 2'd0;
    localparam logic [1:0] MODE_FBK = 2'd1;
    localparam logic [1:0] MODE_FIR = 2'd2;

    localparam logic [TAPS_W-1:0]        TAPS_RST  = 5'd16;
    localparam logic signed [COEF_W-1:0] UNITY_Q14 = 16'sd16384;

    typedef struct packed {
        logic [1:0]               kind;
        logic [3:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [SMP_W-1:0]  sample;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered;
        logic                    clipped;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SCL,
        ST_SUM,
        ST_RND,
        ST_TAP,
        ST_DRN1,
        ST_DRN2
    } t_state;

    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic acc;       // form x*b0 + z0
        logic scl;       // multiply acc by lead_recip
        logic sum;       // combine partial products
        logic rnd;       // round, saturate, load output
        logic tap;       // issue delay entry read
        logic tap_last;  // issued entry is the last one
    } t_cmd;

    typedef struct packed {
        logic is_sample;
    } t_sts;

endpackage

FILE: sv/tff_chan_if.sv
// Valid/ready channel carrying one word of type T.
// No dependencies; the payload type comes from the instance.
interface tff_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/tff_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module tff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tff_ctrl.sv
// Sequencer of the transposed form filter: input/output handshake and tap walk.
// Depends on tff_pkg; drives tff_dp through t_cmd.
module tff_ctrl
    import tff_pkg::*;
#(
    parameter int MAX_TAPS = 16,
    localparam int AW = $clog2(MAX_TAPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TAPS_W-1:0] i_taps,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  t_sts              i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_cmd              o_cmd,
    output logic [AW-1:0]     o_rd_idx
);

    t_state        r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic          r_out_valid, n_out_valid;
    logic [AW-1:0] w_last;

    // clamp the tap count to [2, MAX_TAPS]; walk runs k = 1 .. n-1
    always_comb begin
        priority if (i_taps < 5'd2) begin
            w_last = AW'(1);
        end else if (int'(i_taps) > MAX_TAPS) begin
            w_last = AW'(MAX_TAPS - 1);
        end else begin
            w_last = AW'(i_taps - 5'd1);
        end
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_rd_idx   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_ACC: o_cmd.acc = 1'b1;
            ST_SCL: o_cmd.scl = 1'b1;
            ST_SUM: o_cmd.sum = 1'b1;
            ST_RND: o_cmd.rnd = !r_out_valid || i_out_ready;
            ST_TAP: begin
                o_cmd.tap      = 1'b1;
                o_cmd.tap_last = (r_k == w_last);
                o_rd_idx       = r_k;
            end
            ST_DRN1, ST_DRN2: ;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.is_sample) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: n_state = ST_SCL;
            ST_SCL: n_state = ST_SUM;
            ST_SUM: n_state = ST_RND;
            ST_RND: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_TAP;
                    n_k     = AW'(1);
                end
            end
            ST_TAP: begin
                if (r_k == w_last) begin
                    n_state = ST_DRN1;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            ST_DRN1: n_state = ST_DRN2;
            ST_DRN2: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.rnd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/tff_dp.sv
// Datapath of the transposed form filter: coefficient and delay stores,
// two shared multipliers, rounding and the tap update pipeline.
// Depends on tff_pkg and tff_ram; steered by tff_ctrl through t_cmd.
module tff_dp
    import tff_pkg::*;
#(
    parameter int MAX_TAPS = 16,
    localparam int AW = $clog2(MAX_TAPS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [AW-1:0]            i_rd_idx,
    input  t_in_word                 i_word,
    input  logic [1:0]               i_mode,
    input  logic signed [COEF_W-1:0] i_recip,
    output t_sts                     o_sts,
    output t_out_word                o_word
);

    // entry valid bits: an unwritten entry reads as zero
    logic [MAX_TAPS-1:0] r_bvld, r_avld, r_zvld;
    logic                r_bq_vld, r_aq_vld, r_zq_vld;

    logic [COEF_W-1:0] w_b_rd, w_a_rd;
    logic [DLY_W-1:0]  w_z_rd;

    logic [AW-1:0] w_widx;
    logic          w_idx_ok, w_b_we, w_a_we;
    logic          w_fwd, w_fbk;

    logic signed [SMP_W-1:0]  r_x;
    logic signed [COEF_W-1:0] w_b, w_a, w_b0, w_bk, w_ak;
    logic signed [DLY_W-1:0]  w_z;
    logic signed [31:0]       w_p0;
    logic signed [ACC_W-1:0]  w_acc, r_acc;

    logic signed [OP_W-1:0]   w_ma_op, w_mb_op;
    logic signed [COEF_W-1:0] w_ma_cf, w_mb_cf;
    logic signed [PRD_W-1:0]  w_ma, w_mb, r_prod_a, r_prod_b;

    logic signed [SCL_W-1:0]  w_scaled, r_scaled, w_rs;
    logic signed [ACC_W-1:0]  w_rf;
    logic signed [RND_W-1:0]  w_t;
    logic signed [SMP_W-1:0]  w_y, r_y;
    logic                     w_clip, r_clip;

    logic                    r_s1_vld, r_s1_last, r_s2_vld;
    logic [AW-1:0]           r_s1_idx, r_s2_idx, w_z_waddr;
    logic signed [DLY_W-1:0] r_zt, w_zsat;
    logic signed [SUM_W-1:0] w_sum;

    assign o_sts.is_sample = (i_word.kind == KIND_SAMPLE);

    assign w_fwd = (i_mode != MODE_FBK);
    assign w_fbk = (i_mode != MODE_FIR);

    // coefficient writes; positions past the table are dropped
    assign w_widx   = AW'(i_word.coef_index);
    assign w_idx_ok = int'(i_word.coef_index) < MAX_TAPS;
    assign w_b_we   = i_cmd.accept && (i_word.kind == KIND_FWD) && w_idx_ok;
    assign w_a_we   = i_cmd.accept && (i_word.kind == KIND_FBK) && w_idx_ok;

    tff_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_widx),
        .i_wdata (i_word.coef_value),
        .i_raddr (i_rd_idx),
        .o_rdata (w_b_rd)
    );

    tff_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_fbk_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_widx),
        .i_wdata (i_word.coef_value),
        .i_raddr (i_rd_idx),
        .o_rdata (w_a_rd)
    );

    // the top entry is never written; the carried term of the last tap is forced to zero
    tff_ram #(.WIDTH(DLY_W), .DEPTH(MAX_TAPS)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_vld),
        .i_waddr (w_z_waddr),
        .i_wdata (w_zsat),
        .i_raddr (i_rd_idx),
        .o_rdata (w_z_rd)
    );

    assign w_b = r_bq_vld ? $signed(w_b_rd) : '0;
    assign w_a = r_aq_vld ? $signed(w_a_rd) : '0;
    assign w_z = r_zq_vld ? $signed(w_z_rd) : '0;

    // head: acc = x*b0 + z0, b0 taken as 1.0 when the forward table is off
    assign w_b0  = w_fwd ? w_b : UNITY_Q14;
    assign w_p0  = r_x * w_b0;
    assign w_acc = ACC_W'(w_p0) + ACC_W'(w_z);

    // shared multipliers: acc halves times lead_recip, or x*b[k] and y*a[k]
    assign w_bk    = w_fwd ? w_b : '0;
    assign w_ak    = w_fbk ? w_a : '0;
    assign w_ma_op = i_cmd.scl ? $signed({1'b0, r_acc[ACC_SPLIT-1:0]}) : OP_W'(r_x);
    assign w_mb_op = i_cmd.scl ? OP_W'($signed(r_acc[ACC_W-1:ACC_SPLIT])) : OP_W'(r_y);
    assign w_ma_cf = i_cmd.scl ? i_recip : w_bk;
    assign w_mb_cf = i_cmd.scl ? i_recip : w_ak;
    assign w_ma    = w_ma_op * w_ma_cf;
    assign w_mb    = w_mb_op * w_mb_cf;

    assign w_scaled = (SCL_W'(r_prod_b) <<< ACC_SPLIT) + SCL_W'(r_prod_a);

    // round half up, then saturate to Q1.15
    assign w_rs = r_scaled + (SCL_W'(1) <<< 27);
    assign w_rf = r_acc + (ACC_W'(1) <<< 13);
    assign w_t  = w_fbk ? $signed(w_rs[SCL_W-1:28]) : RND_W'($signed(w_rf[ACC_W-1:14]));

    always_comb begin
        priority if (w_t > 29'sd32767) begin
            w_y    = 16'sh7FFF;
            w_clip = 1'b1;
        end else if (w_t < -29'sd32768) begin
            w_y    = -16'sh8000;
            w_clip = 1'b1;
        end else begin
            w_y    = w_t[SMP_W-1:0];
            w_clip = 1'b0;
        end
    end

    // tap update: z[k-1] = sat40(z[k] + x*b[k] - y*a[k])
    assign w_sum     = SUM_W'(r_zt) + SUM_W'(r_prod_a) - SUM_W'(r_prod_b);
    assign w_z_waddr = r_s2_idx - AW'(1);

    always_comb begin
        priority if (!w_sum[SUM_W-1] && (w_sum[SUM_W-2:DLY_W-1] != 2'b00)) begin
            w_zsat = {1'b0, {(DLY_W-1){1'b1}}};
        end else if (w_sum[SUM_W-1] && (w_sum[SUM_W-2:DLY_W-1] != 2'b11)) begin
            w_zsat = {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            w_zsat = w_sum[DLY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld   <= '0;
            r_avld   <= '0;
            r_zvld   <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_b_we) begin
                r_bvld[w_widx] <= 1'b1;
            end
            if (w_a_we) begin
                r_avld[w_widx] <= 1'b1;
            end
            if (r_s2_vld) begin
                r_zvld[w_z_waddr] <= 1'b1;
            end
            r_s1_vld <= i_cmd.tap;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bq_vld  <= r_bvld[i_rd_idx];
        r_aq_vld  <= r_avld[i_rd_idx];
        r_zq_vld  <= r_zvld[i_rd_idx];
        r_s1_last <= i_cmd.tap_last;
        r_s1_idx  <= i_rd_idx;
        r_s2_idx  <= r_s1_idx;
        r_zt      <= r_s1_last ? '0 : w_z;
        if (i_cmd.accept) begin
            r_x <= i_word.sample;
        end
        if (i_cmd.acc) begin
            r_acc <= w_acc;
        end
        if (i_cmd.scl || r_s1_vld) begin
            r_prod_a <= w_ma;
            r_prod_b <= w_mb;
        end
        if (i_cmd.sum) begin
            r_scaled <= w_scaled;
        end
        if (i_cmd.rnd) begin
            r_y    <= w_y;
            r_clip <= w_clip;
        end
    end

    // y doubles as the output register
    assign o_word.filtered = r_y;
    assign o_word.clipped  = r_clip;

endmodule

FILE: sv/transposed_form_iir_fir_filter.sv
// Transposed direct form II filter, pole-zero / all-pole / FIR.
// Coefficient words are taken while idle. A sample word walks ACC, SCL, SUM,
// RND (held while the output is full), one TAP per delay entry k = 1 .. n-1,
// DRN1 and DRN2; the next word is taken back in idle. Reset (synchronous,
// active low) zeroes tables and delay line through entry valid bits at once,
// restores the control and config registers; no clearing pass.
module transposed_form_iir_fir_filter
    import tff_pkg::*;
#(
    parameter int MAX_TAPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tff_chan_if.sink              i_in,
    tff_chan_if.source            o_out
);

`include "transposed_form_iir_fir_filter_defines.svh"

    localparam int AW = $clog2(MAX_TAPS);

    logic [1:0]               r_mode;
    logic [TAPS_W-1:0]        r_taps;
    logic signed [COEF_W-1:0] r_recip;

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [AW-1:0] w_rd_idx;
    logic          w_in_ready, w_out_valid;
    t_in_word      w_in_word;
    t_out_word     w_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PZ;
            r_taps  <= TAPS_RST;
            r_recip <= UNITY_Q14;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_TAPS:  r_taps  <= i_cfg_data[TAPS_W-1:0];
                CFG_RECIP: r_recip <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_in_word = i_in.data;

    tff_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_taps      (r_taps),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .o_rd_idx    (w_rd_idx)
    );

    tff_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_rd_idx (w_rd_idx),
        .i_word   (w_in_word),
        .i_mode   (r_mode),
        .i_recip  (r_recip),
        .o_sts    (w_sts),
        .o_word   (w_out_word)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_word;

    `TFF_ASSERT_SAME(a_rnd_free, w_cmd.rnd, !o_out.valid || o_out.ready, "result overwritten")
    `TFF_ASSERT_SAME(a_out_src, $rose(o_out.valid), $past(w_cmd.rnd), "output without result")
    `TFF_ASSERT_NEXT(a_smp_busy, i_in.valid && i_in.ready && i_in.data.kind == KIND_SAMPLE,
        !i_in.ready, "word taken during sample")

endmodule
